@@ src/rtt_histogram_percentile_unit_macros.svh @@
// Assertion macros shared by the histogram percentile unit.
`ifndef RTT_HISTOGRAM_PERCENTILE_UNIT_MACROS_SVH
`define RTT_HISTOGRAM_PERCENTILE_UNIT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define RHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rhp_pkg.sv @@
// Types and constants of the histogram percentile unit.
package rhp_pkg;

    localparam int EDGE_NUM = 8;
    localparam int EDGE_IW  = 3;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int SUM_W    = 35;
    localparam int PCT_W    = 7;
    localparam int SCALE_W  = 39;
    localparam int ACC_W    = 42;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_QUERY  = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_RSVD   = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIN,
        ST_MAX,
        ST_CNT,
        ST_EDGE,
        ST_INC,
        ST_SUM,
        ST_MUL,
        ST_SCALE,
        ST_WALK,
        ST_DONE
    } t_state;

    typedef logic [EDGE_NUM-1:0][DATA_W-1:0] t_edge_bank;

    localparam t_edge_bank EDGE_RESET = {
        32'hFFFF_FFFF, 32'd100000, 32'd50000, 32'd20000,
        32'd10000, 32'd5000, 32'd2000, 32'd1000
    };

    typedef struct packed {
        logic [ACC_W-1:0] a;
        logic [ACC_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ACC_W-1:0] res;
        logic             borrow;
        logic             zero;
    } t_alu_rsp;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] low_edge;
        logic [DATA_W-1:0] high_edge;
        logic [DATA_W-1:0] min_us;
        logic [DATA_W-1:0] max_us;
        logic [DATA_W-1:0] count;
    } t_result;

endpackage

@@ src/rtt_histogram_percentile_unit.sv @@
// Top level of the round-trip-time histogram percentile unit.
//
// Channel | Dir | Handshake                | Fields
// in      | in  | i_in_valid / o_in_stall  | i_mode, i_sample_us, i_percent
// out     | out | o_out_valid / i_out_stall| o_found, o_low_edge_us, o_high_edge_us,
//         |     |                          | o_min_us, o_max_us, o_sample_count
// cfg     | in  | APB psel/penable/pready  | paddr, pwdata, prdata
//
// Sample: update minimum, maximum and count, compare against the edges in turn, increment the bucket, finish.
// Query: sum the bucket counts, multiply by the percentage, scale and compare per bucket walked, finish.
// Clear and unused mode go straight to finish; the unit returns to idle before it takes the next item.
// Compares, counts, sums and the walk share one 42-bit adder.
// Synchronous active-low reset; counts and statistics clear at once.
// A stalled result holds; the next item is taken while it waits.
`include "rtt_histogram_percentile_unit_macros.svh"

module rtt_histogram_percentile_unit #(
    parameter int BUCKETS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_mode,
    input  logic [31:0]                 i_sample_us,
    input  logic [7:0]                  i_percent,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [31:0]                 o_low_edge_us,
    output logic [31:0]                 o_high_edge_us,
    output logic [31:0]                 o_min_us,
    output logic [31:0]                 o_max_us,
    output logic [31:0]                 o_sample_count,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rhp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    rhp_pkg::t_edge_bank edges;
    rhp_pkg::t_alu_req   alu_req;
    rhp_pkg::t_alu_rsp   alu_rsp;
    rhp_pkg::t_result    seq_result;
    logic                busy;
    logic                done;
    logic                out_free;
    logic                in_take;

    logic             r_out_valid, n_out_valid;
    rhp_pkg::t_result r_out, n_out;

    assign o_in_stall = busy;
    assign in_take    = i_in_valid && !busy;
    assign out_free   = !r_out_valid || !i_out_stall;

    rhp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_edges (edges)
    );

    rhp_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    rhp_seq #(
        .BUCKETS (BUCKETS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_take),
        .i_mode      (rhp_pkg::t_mode'(i_mode)),
        .i_sample_us (i_sample_us),
        .i_percent   (i_percent),
        .i_edges     (edges),
        .i_out_free  (out_free),
        .i_alu_rsp   (alu_rsp),
        .o_alu_req   (alu_req),
        .o_busy      (busy),
        .o_done      (done),
        .o_result    (seq_result)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (done && out_free) begin
            n_out_valid = 1'b1;
            n_out       = seq_result;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out.found;
    assign o_low_edge_us  = r_out.low_edge;
    assign o_high_edge_us = r_out.high_edge;
    assign o_min_us       = r_out.min_us;
    assign o_max_us       = r_out.max_us;
    assign o_sample_count = r_out.count;

    `RHP_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_take, o_in_stall, "item taken but unit not busy")
    `RHP_ASSERT_NEXT(a_result_posted, i_clk, i_rst_n, done && out_free, o_out_valid, "finished item not posted")

endmodule

@@ src/rhp_alu.sv @@
// Shared add/subtract and compare unit.
module rhp_alu (
    input  rhp_pkg::t_alu_req i_req,
    output rhp_pkg::t_alu_rsp o_rsp
);

    logic [rhp_pkg::ACC_W:0] sum;
    logic [rhp_pkg::ACC_W-1:0] b_eff;

    assign b_eff = i_req.sub ? ~i_req.b : i_req.b;
    assign sum   = {1'b0, i_req.a} + {1'b0, b_eff}
                 + {{rhp_pkg::ACC_W{1'b0}}, i_req.sub};

    assign o_rsp.res    = sum[rhp_pkg::ACC_W-1:0];
    assign o_rsp.borrow = i_req.sub & ~sum[rhp_pkg::ACC_W];
    assign o_rsp.zero   = (sum[rhp_pkg::ACC_W-1:0] == '0);

endmodule

@@ src/rhp_regs.sv @@
// Bucket edge registers behind the APB port.
module rhp_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rhp_pkg::ADDR_W-1:0]  paddr,
    input  logic [rhp_pkg::DATA_W-1:0]  pwdata,
    output logic [rhp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output rhp_pkg::t_edge_bank         o_edges
);

    rhp_pkg::t_edge_bank r_edges, n_edges;
    logic [rhp_pkg::EDGE_IW-1:0] sel;

    assign sel    = paddr[rhp_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign prdata = r_edges[sel];
    assign o_edges = r_edges;

    always_comb begin
        n_edges = r_edges;
        if (psel && penable && pwrite && pready) begin
            n_edges[sel] = pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edges <= rhp_pkg::EDGE_RESET;
        end else begin
            r_edges <= n_edges;
        end
    end

endmodule

@@ src/rhp_seq.sv @@
// Sequencer, bucket counts and running statistics.
`include "rtt_histogram_percentile_unit_macros.svh"

module rhp_seq #(
    parameter int BUCKETS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  rhp_pkg::t_mode              i_mode,
    input  logic [rhp_pkg::DATA_W-1:0]  i_sample_us,
    input  logic [7:0]                  i_percent,
    input  rhp_pkg::t_edge_bank         i_edges,
    input  logic                        i_out_free,
    input  rhp_pkg::t_alu_rsp           i_alu_rsp,
    output rhp_pkg::t_alu_req           o_alu_req,
    output logic                        o_busy,
    output logic                        o_done,
    output rhp_pkg::t_result            o_result
);

    localparam int IW = $clog2(BUCKETS);
    localparam logic [IW-1:0] LAST = IW'(BUCKETS - 1);
    localparam logic [rhp_pkg::EDGE_IW-1:0] TOP_HI = rhp_pkg::EDGE_IW'(BUCKETS - 1);
    localparam logic [rhp_pkg::EDGE_IW-1:0] TOP_LO = rhp_pkg::EDGE_IW'(BUCKETS - 2);

    rhp_pkg::t_state r_state, n_state;
    logic [rhp_pkg::DATA_W-1:0]  r_sample, n_sample;
    logic [rhp_pkg::PCT_W-1:0]   r_pct, n_pct;
    logic [IW-1:0]               r_idx, n_idx;
    logic [rhp_pkg::ACC_W-1:0]   r_acc, n_acc;
    logic [rhp_pkg::SCALE_W-1:0] r_c100, n_c100;
    logic [BUCKETS-1:0][rhp_pkg::DATA_W-1:0] r_counts, n_counts;
    logic [rhp_pkg::DATA_W-1:0]  r_min, n_min;
    logic [rhp_pkg::DATA_W-1:0]  r_max, n_max;
    logic [rhp_pkg::DATA_W-1:0]  r_samples, n_samples;
    logic                        r_found, n_found;
    logic [rhp_pkg::DATA_W-1:0]  r_low, n_low;
    logic [rhp_pkg::DATA_W-1:0]  r_high, n_high;

    logic [rhp_pkg::EDGE_IW-1:0] eidx;
    logic [rhp_pkg::DATA_W-1:0]  edge_cur;
    logic [rhp_pkg::DATA_W-1:0]  edge_prev;
    logic [rhp_pkg::DATA_W-1:0]  count_cur;

    assign eidx      = rhp_pkg::EDGE_IW'(r_idx);
    assign edge_cur  = i_edges[eidx];
    assign edge_prev = (r_idx == '0) ? '0 : i_edges[eidx - rhp_pkg::EDGE_IW'(1)];
    assign count_cur = r_counts[r_idx];

    assign o_busy = (r_state != rhp_pkg::ST_IDLE);

    assign o_result.found     = r_found;
    assign o_result.low_edge  = r_low;
    assign o_result.high_edge = r_high;
    assign o_result.min_us    = r_min;
    assign o_result.max_us    = r_max;
    assign o_result.count     = r_samples;

    always_comb begin
        n_state   = r_state;
        n_sample  = r_sample;
        n_pct     = r_pct;
        n_idx     = r_idx;
        n_acc     = r_acc;
        n_c100    = r_c100;
        n_counts  = r_counts;
        n_min     = r_min;
        n_max     = r_max;
        n_samples = r_samples;
        n_found   = r_found;
        n_low     = r_low;
        n_high    = r_high;
        o_alu_req = '0;
        o_done    = 1'b0;
        unique case (r_state)
            rhp_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_sample = i_sample_us;
                    n_pct    = (i_percent > 8'(rhp_pkg::PCT_MAX)) ? rhp_pkg::PCT_MAX
                                                                  : i_percent[rhp_pkg::PCT_W-1:0];
                    n_idx    = '0;
                    n_acc    = '0;
                    n_found  = 1'b0;
                    n_low    = '0;
                    n_high   = '0;
                    unique case (i_mode)
                        rhp_pkg::MODE_SAMPLE: n_state = rhp_pkg::ST_MIN;
                        rhp_pkg::MODE_QUERY:  n_state = rhp_pkg::ST_SUM;
                        rhp_pkg::MODE_CLEAR: begin
                            n_counts  = '0;
                            n_min     = '1;
                            n_max     = '0;
                            n_samples = '0;
                            n_state   = rhp_pkg::ST_DONE;
                        end
                        rhp_pkg::MODE_RSVD:   n_state = rhp_pkg::ST_DONE;
                        default:              n_state = rhp_pkg::ST_DONE;
                    endcase
                end
            end
            rhp_pkg::ST_MIN: begin
                o_alu_req.a   = rhp_pkg::ACC_W'(r_sample);
                o_alu_req.b   = rhp_pkg::ACC_W'(r_min);
                o_alu_req.sub = 1'b1;
                if (i_alu_rsp.borrow) begin
                    n_min = r_sample;
                end
                n_state = rhp_pkg::ST_MAX;
            end
            rhp_pkg::ST_MAX: begin
                o_alu_req.a   = rhp_pkg::ACC_W'(r_max);
                o_alu_req.b   = rhp_pkg::ACC_W'(r_sample);
                o_alu_req.sub = 1'b1;
                if (i_alu_rsp.borrow) begin
                    n_max = r_sample;
                end
                n_state = rhp_pkg::ST_CNT;
            end
            rhp_pkg::ST_CNT: begin
                o_alu_req.a = rhp_pkg::ACC_W'(r_samples);
                o_alu_req.b = rhp_pkg::ACC_W'(1);
                n_samples   = i_alu_rsp.res[rhp_pkg::DATA_W-1:0];
                n_state     = rhp_pkg::ST_EDGE;
            end
            rhp_pkg::ST_EDGE: begin
                o_alu_req.a   = rhp_pkg::ACC_W'(edge_cur);
                o_alu_req.b   = rhp_pkg::ACC_W'(r_sample);
                o_alu_req.sub = 1'b1;
                if (!i_alu_rsp.borrow) begin
                    n_state = rhp_pkg::ST_INC;
                end else if (r_idx == LAST) begin
                    n_state = rhp_pkg::ST_DONE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            rhp_pkg::ST_INC: begin
                o_alu_req.a = rhp_pkg::ACC_W'(count_cur);
                o_alu_req.b = rhp_pkg::ACC_W'(1);
                if (!(&count_cur)) begin
                    n_counts[r_idx] = i_alu_rsp.res[rhp_pkg::DATA_W-1:0];
                end
                n_state = rhp_pkg::ST_DONE;
            end
            rhp_pkg::ST_SUM: begin
                o_alu_req.a = r_acc;
                o_alu_req.b = rhp_pkg::ACC_W'(count_cur);
                n_acc       = i_alu_rsp.res;
                if (r_idx == LAST) begin
                    n_idx   = '0;
                    n_state = rhp_pkg::ST_MUL;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            rhp_pkg::ST_MUL: begin
                if (r_acc == '0) begin
                    n_state = rhp_pkg::ST_DONE;
                end else begin
                    n_acc = (r_pct == '0) ? rhp_pkg::ACC_W'(1)
                          : rhp_pkg::ACC_W'(r_acc[rhp_pkg::SUM_W-1:0])
                            * rhp_pkg::ACC_W'(r_pct);
                    n_state = rhp_pkg::ST_SCALE;
                end
            end
            rhp_pkg::ST_SCALE: begin
                n_c100  = rhp_pkg::SCALE_W'(count_cur)
                        * rhp_pkg::SCALE_W'(rhp_pkg::PCT_MAX);
                n_state = rhp_pkg::ST_WALK;
            end
            rhp_pkg::ST_WALK: begin
                o_alu_req.a   = r_acc;
                o_alu_req.b   = rhp_pkg::ACC_W'(r_c100);
                o_alu_req.sub = 1'b1;
                if (i_alu_rsp.borrow || i_alu_rsp.zero) begin
                    n_found = 1'b1;
                    n_low   = edge_prev;
                    n_high  = edge_cur;
                    n_state = rhp_pkg::ST_DONE;
                end else if (r_idx == LAST) begin
                    n_found = 1'b1;
                    n_low   = i_edges[TOP_LO];
                    n_high  = i_edges[TOP_HI];
                    n_state = rhp_pkg::ST_DONE;
                end else begin
                    n_acc   = i_alu_rsp.res;
                    n_idx   = r_idx + IW'(1);
                    n_state = rhp_pkg::ST_SCALE;
                end
            end
            rhp_pkg::ST_DONE: begin
                o_done = 1'b1;
                if (i_out_free) begin
                    n_state = rhp_pkg::ST_IDLE;
                end
            end
            default: n_state = rhp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rhp_pkg::ST_IDLE;
            r_counts  <= '0;
            r_min     <= '1;
            r_max     <= '0;
            r_samples <= '0;
        end else begin
            r_state   <= n_state;
            r_counts  <= n_counts;
            r_min     <= n_min;
            r_max     <= n_max;
            r_samples <= n_samples;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_pct    <= n_pct;
        r_idx    <= n_idx;
        r_acc    <= n_acc;
        r_c100   <= n_c100;
        r_found  <= n_found;
        r_low    <= n_low;
        r_high   <= n_high;
    end

    `RHP_ASSERT_NOW(a_walk_rank_left, i_clk, i_rst_n, r_state == rhp_pkg::ST_WALK, r_acc != '0, "percentile walk running with no rank left")
    `RHP_ASSERT_NOW(a_min_le_max, i_clk, i_rst_n, (r_state == rhp_pkg::ST_IDLE) && (r_max != '0), r_min <= r_max, "running minimum above running maximum")

endmodule
